FILE: design/sprite_clip_frame_sequencer_assert.svh
// ---------------------------------------------------------------------------
// sprite_clip_frame_sequencer_assert.svh
// Assertion macros shared by the sprite clip frame sequencer checkers.
// ---------------------------------------------------------------------------
`ifndef SPRITE_CLIP_FRAME_SEQUENCER_ASSERT_SVH
`define SPRITE_CLIP_FRAME_SEQUENCER_ASSERT_SVH

// same-cycle implication, off during reset
`define SCFS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scfs check failed");

// next-cycle implication, off during reset
`define SCFS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scfs check failed");

`endif

FILE: design/scfs_pkg.sv
// ---------------------------------------------------------------------------
// scfs_pkg
// Types and constants of the sprite clip frame sequencer.
// ---------------------------------------------------------------------------
package scfs_pkg;

  localparam int CLIP_COUNT_DEF        = 16;
  localparam int FRAMES_PER_CLIP_DEF   = 64;
  localparam int FRAME_NUMBER_BITS_DEF = 10;

  localparam int CFG_DATA_W  = 24;
  localparam int CFG_INDEX_W = 3;
  localparam int PERIOD_W    = 24;
  localparam int COLS_W      = 10;
  localparam int CELL_W      = 12;
  localparam int RECT_W      = 22;
  localparam int FRAME_W     = 10;
  localparam int ACC_W       = 32;
  localparam int DIV_W       = 33;
  localparam int DIVISOR_W   = 24;
  localparam int STEP_W      = 6;

  localparam logic [PERIOD_W-1:0] FRAME_PERIOD_RST = 24'd16667;
  localparam logic [COLS_W-1:0]   SHEET_COLS_RST   = 10'd1;
  localparam logic [CELL_W-1:0]   CELL_WIDTH_RST   = 12'd32;
  localparam logic [CELL_W-1:0]   CELL_HEIGHT_RST  = 12'd32;
  localparam logic                LOOP_ENABLE_RST  = 1'b1;

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_WRITE  = 3'd1,
    OP_SELECT = 3'd2,
    OP_PLAY   = 3'd3,
    OP_PAUSE  = 3'd4
  } op_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_FRAME_PERIOD  = 3'd0,
    CFG_SHEET_COLUMNS = 3'd1,
    CFG_CELL_WIDTH    = 3'd2,
    CFG_CELL_HEIGHT   = 3'd3,
    CFG_LOOP_ENABLE   = 3'd4
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_CMP,
    ST_DIVN,
    ST_STEP,
    ST_DIVP,
    ST_READ,
    ST_SELRD,
    ST_LOAD,
    ST_RECT,
    ST_DIVR,
    ST_MUL,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [2:0]  operation;
    logic [19:0] time_delta;
    logic [3:0]  clip_id;
    logic [5:0]  slot;
    logic [9:0]  frame_value;
    logic [6:0]  clip_length;
    logic        clip_mirror;
  } in_word_t;

  typedef struct packed {
    logic [21:0] rect_x;
    logic [21:0] rect_y;
    logic [9:0]  shown_frame;
    logic        mirrored;
    logic        is_paused;
  } out_word_t;

endpackage

FILE: design/sprite_clip_frame_sequencer.sv
// ---------------------------------------------------------------------------
// sprite_clip_frame_sequencer
// Animation clip table with frame timer; returns the sheet cell of the
// shown frame for every input word.
// ---------------------------------------------------------------------------
// One word is processed at a time; the next word is taken while the previous
// result still sits in the output register. Frame count, position wrap and
// cell lookup share one restoring divider that retires one quotient bit per
// cycle. Every word ends with the cell lookup (frame div/mod columns); write,
// play, pause, unknown codes and paused ticks go straight to it. A select
// first reads entry 0 of the new clip from the frame table. A running tick
// that advances first divides the accumulator by the period for the frame
// count, then steps the position and reads the frame table; in looping mode
// the stepped position is taken mod the clip length before the read. A
// result still waiting in the output register holds the next one, and the
// input, until it is taken. The frame table is a synchronous RAM with a
// registered read; its contents are undefined until written.
module sprite_clip_frame_sequencer #(
  parameter int CLIP_COUNT        = scfs_pkg::CLIP_COUNT_DEF,
  parameter int FRAMES_PER_CLIP   = scfs_pkg::FRAMES_PER_CLIP_DEF,
  parameter int FRAME_NUMBER_BITS = scfs_pkg::FRAME_NUMBER_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  scfs_pkg::in_word_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output scfs_pkg::out_word_t                out_data,
  input  logic                               cfg_wr_en,
  input  logic [scfs_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [scfs_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int CLIP_W = (CLIP_COUNT > 1) ? $clog2(CLIP_COUNT) : 1;
  localparam int POS_W  = (FRAMES_PER_CLIP > 1) ? $clog2(FRAMES_PER_CLIP) : 1;
  localparam int LEN_W  = $clog2(FRAMES_PER_CLIP + 1);
  localparam int DEPTH  = CLIP_COUNT * FRAMES_PER_CLIP;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FNB    = FRAME_NUMBER_BITS;
  localparam int PAD_W  = scfs_pkg::DIV_W - FNB;
  localparam int PROD_W = FNB + scfs_pkg::CELL_W;
  localparam int XPR_W  = scfs_pkg::RECT_W;
  localparam int WIDE_W = 16;

  localparam int ACC_W  = scfs_pkg::ACC_W;
  localparam int DIV_W  = scfs_pkg::DIV_W;
  localparam int DVS_W  = scfs_pkg::DIVISOR_W;
  localparam int STEP_W = scfs_pkg::STEP_W;

  // configuration
  logic [scfs_pkg::PERIOD_W-1:0] period_r;
  logic [scfs_pkg::COLS_W-1:0]   cols_r;
  logic [scfs_pkg::CELL_W-1:0]   cw_r;
  logic [scfs_pkg::CELL_W-1:0]   ch_r;
  logic                          loop_r;

  // control state
  scfs_pkg::state_t state_r, state_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic              paused_r, paused_nxt;
  logic [CLIP_W-1:0] sel_r, sel_nxt;
  logic [FNB-1:0]    cf_r, cf_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [LEN_W-1:0]  len_tab_r [CLIP_COUNT];
  logic              mir_tab_r [CLIP_COUNT];

  // working payload
  scfs_pkg::in_word_t  in_r, in_nxt;
  scfs_pkg::out_word_t out_data_r, out_data_nxt;
  logic [ACC_W-1:0]            n_r, n_nxt;
  logic [POS_W-1:0]            p_r, p_nxt;
  logic [scfs_pkg::COLS_W-1:0] col_r, col_nxt;
  logic [FNB-1:0]              row_r, row_nxt;
  logic [XPR_W-1:0]            rx_r, rx_nxt;
  logic [XPR_W-1:0]            ry_r, ry_nxt;

  // frame table
  logic [FNB-1:0]    frame_mem [DEPTH];
  logic [FNB-1:0]    rd_data_r;
  logic              mem_we;
  logic              rd_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] sel_base;
  logic [FNB-1:0]    wr_frame;
  logic              tab_we;
  logic [CLIP_W-1:0] wr_clip;
  logic [LEN_W-1:0]  len_store;
  logic [LEN_W-1:0]  len_cur;

  // shared divider
  logic              dv_busy_r;
  logic [DIV_W-1:0]  dv_dvd_r;
  logic [DIV_W-1:0]  dv_quo_r;
  logic [DVS_W-1:0]  dv_rem_r;
  logic [DVS_W-1:0]  dv_div_r;
  logic [STEP_W-1:0] dv_cnt_r;
  logic              dv_start;
  logic [DIV_W-1:0]  dv_dvd_in;
  logic [DVS_W-1:0]  dv_div_in;
  logic [STEP_W-1:0] dv_steps_in;
  logic [DVS_W:0]    dv_trial;
  logic [DVS_W:0]    dv_diff;
  logic              dv_ge;
  logic [DVS_W-1:0]  dv_rem_nxt;

  logic [scfs_pkg::PERIOD_W-1:0] period_eff;
  logic [scfs_pkg::COLS_W-1:0]   cols_eff;
  logic [DIV_W-1:0]              step_sum;
  logic [WIDE_W-1:0]             fval_w;
  logic [WIDE_W-1:0]             cf_w;
  logic [XPR_W-1:0]              prod_x;
  logic [PROD_W-1:0]             prod_y;

  assign period_eff = (period_r == '0) ? scfs_pkg::PERIOD_W'(1) : period_r;
  assign cols_eff   = (cols_r == '0) ? scfs_pkg::COLS_W'(1) : cols_r;
  assign len_cur    = len_tab_r[sel_r];
  assign step_sum   = DIV_W'(p_r) + DIV_W'(n_r);
  assign fval_w     = WIDE_W'(in_r.frame_value);
  assign wr_frame   = fval_w[FNB-1:0];
  assign cf_w       = WIDE_W'(cf_r);
  assign wr_clip    = CLIP_W'(in_r.clip_id);
  assign wr_addr    = ADDR_W'(wr_clip) * ADDR_W'(FRAMES_PER_CLIP) + ADDR_W'(in_r.slot);
  assign sel_base   = ADDR_W'(sel_r) * ADDR_W'(FRAMES_PER_CLIP);
  assign rd_addr    = sel_base + ((state_r == scfs_pkg::ST_READ) ? ADDR_W'(pos_r) : '0);
  assign prod_x     = XPR_W'(col_r) * XPR_W'(cw_r);
  assign prod_y     = PROD_W'(row_r) * PROD_W'(ch_r);

  always_comb begin
    if (in_r.clip_length == '0) begin
      len_store = LEN_W'(1);
    end else if (int'(in_r.clip_length) > FRAMES_PER_CLIP) begin
      len_store = LEN_W'(FRAMES_PER_CLIP);
    end else begin
      len_store = LEN_W'(in_r.clip_length);
    end
  end

  // divider datapath: one restoring step per cycle
  assign dv_trial   = {dv_rem_r, dv_dvd_r[DIV_W-1]};
  assign dv_diff    = dv_trial - {1'b0, dv_div_r};
  assign dv_ge      = (dv_trial >= {1'b0, dv_div_r});
  assign dv_rem_nxt = dv_ge ? dv_diff[DVS_W-1:0] : dv_trial[DVS_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_busy_r <= 1'b0;
    end else if (dv_start) begin
      dv_busy_r <= 1'b1;
    end else if (dv_busy_r && dv_cnt_r == STEP_W'(1)) begin
      dv_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dv_start) begin
      dv_dvd_r <= dv_dvd_in;
      dv_quo_r <= '0;
      dv_rem_r <= '0;
      dv_div_r <= dv_div_in;
      dv_cnt_r <= dv_steps_in;
    end else if (dv_busy_r) begin
      dv_dvd_r <= {dv_dvd_r[DIV_W-2:0], 1'b0};
      dv_quo_r <= {dv_quo_r[DIV_W-2:0], dv_ge};
      dv_rem_r <= dv_rem_nxt;
      dv_cnt_r <= dv_cnt_r - STEP_W'(1);
    end
  end

  // frame table RAM
  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_mem[wr_addr] <= wr_frame;
    end
    if (rd_en) begin
      rd_data_r <= frame_mem[rd_addr];
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= scfs_pkg::FRAME_PERIOD_RST;
      cols_r   <= scfs_pkg::SHEET_COLS_RST;
      cw_r     <= scfs_pkg::CELL_WIDTH_RST;
      ch_r     <= scfs_pkg::CELL_HEIGHT_RST;
      loop_r   <= scfs_pkg::LOOP_ENABLE_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        scfs_pkg::CFG_FRAME_PERIOD:  period_r <= cfg_wdata[scfs_pkg::PERIOD_W-1:0];
        scfs_pkg::CFG_SHEET_COLUMNS: cols_r   <= cfg_wdata[scfs_pkg::COLS_W-1:0];
        scfs_pkg::CFG_CELL_WIDTH:    cw_r     <= cfg_wdata[scfs_pkg::CELL_W-1:0];
        scfs_pkg::CFG_CELL_HEIGHT:   ch_r     <= cfg_wdata[scfs_pkg::CELL_W-1:0];
        scfs_pkg::CFG_LOOP_ENABLE:   loop_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // clip length and mirror tables
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CLIP_COUNT; i++) begin
        len_tab_r[i] <= LEN_W'(1);
        mir_tab_r[i] <= 1'b0;
      end
    end else if (tab_we) begin
      len_tab_r[wr_clip] <= len_store;
      mir_tab_r[wr_clip] <= in_r.clip_mirror;
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    acc_nxt       = acc_r;
    pos_nxt       = pos_r;
    paused_nxt    = paused_r;
    sel_nxt       = sel_r;
    cf_nxt        = cf_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    in_nxt        = in_r;
    n_nxt         = n_r;
    p_nxt         = p_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    rx_nxt        = rx_r;
    ry_nxt        = ry_r;
    dv_start      = 1'b0;
    dv_dvd_in     = '0;
    dv_div_in     = '0;
    dv_steps_in   = '0;
    mem_we        = 1'b0;
    tab_we        = 1'b0;
    rd_en         = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      scfs_pkg::ST_IDLE: begin
        if (in_valid) begin
          in_nxt    = in_data;
          state_nxt = scfs_pkg::ST_EXEC;
        end
      end
      scfs_pkg::ST_EXEC: begin
        state_nxt = scfs_pkg::ST_RECT;
        unique case (in_r.operation)
          scfs_pkg::OP_TICK: begin
            if (!paused_r) begin
              acc_nxt   = acc_r + ACC_W'(in_r.time_delta);
              state_nxt = scfs_pkg::ST_CMP;
            end
          end
          scfs_pkg::OP_WRITE: begin
            if (int'(in_r.clip_id) < CLIP_COUNT) begin
              tab_we = 1'b1;
              mem_we = (int'(in_r.slot) < FRAMES_PER_CLIP);
            end
          end
          scfs_pkg::OP_SELECT: begin
            if (int'(in_r.clip_id) < CLIP_COUNT) begin
              sel_nxt = wr_clip;
            end
            state_nxt = scfs_pkg::ST_SELRD;
          end
          scfs_pkg::OP_PLAY:  paused_nxt = 1'b0;
          scfs_pkg::OP_PAUSE: paused_nxt = 1'b1;
          default: ;
        endcase
      end
      scfs_pkg::ST_CMP: begin
        if (acc_r > ACC_W'(period_eff)) begin
          dv_start    = 1'b1;
          dv_dvd_in   = {acc_r - ACC_W'(1), 1'b0};
          dv_div_in   = DVS_W'(period_eff);
          dv_steps_in = STEP_W'(ACC_W);
          state_nxt   = scfs_pkg::ST_DIVN;
        end else begin
          state_nxt = scfs_pkg::ST_RECT;
        end
      end
      scfs_pkg::ST_DIVN: begin
        if (!dv_busy_r) begin
          acc_nxt = ACC_W'(dv_rem_r) + ACC_W'(1);
          n_nxt   = dv_quo_r[ACC_W-1:0];
          // a shortened clip steps from its last entry
          p_nxt   = (int'(pos_r) < int'(len_cur)) ? pos_r : POS_W'(len_cur - LEN_W'(1));
          state_nxt = scfs_pkg::ST_STEP;
        end
      end
      scfs_pkg::ST_STEP: begin
        if (loop_r) begin
          dv_start    = 1'b1;
          dv_dvd_in   = step_sum;
          dv_div_in   = DVS_W'(len_cur);
          dv_steps_in = STEP_W'(DIV_W);
          state_nxt   = scfs_pkg::ST_DIVP;
        end else if (step_sum >= DIV_W'(len_cur)) begin
          pos_nxt    = POS_W'(len_cur - LEN_W'(1));
          paused_nxt = 1'b1;
          state_nxt  = scfs_pkg::ST_READ;
        end else begin
          pos_nxt   = POS_W'(step_sum);
          state_nxt = scfs_pkg::ST_READ;
        end
      end
      scfs_pkg::ST_DIVP: begin
        if (!dv_busy_r) begin
          pos_nxt   = POS_W'(dv_rem_r);
          state_nxt = scfs_pkg::ST_READ;
        end
      end
      scfs_pkg::ST_READ: begin
        rd_en     = 1'b1;
        state_nxt = scfs_pkg::ST_LOAD;
      end
      scfs_pkg::ST_SELRD: begin
        rd_en     = 1'b1;
        state_nxt = scfs_pkg::ST_LOAD;
      end
      scfs_pkg::ST_LOAD: begin
        cf_nxt    = rd_data_r;
        state_nxt = scfs_pkg::ST_RECT;
      end
      scfs_pkg::ST_RECT: begin
        dv_start    = 1'b1;
        dv_dvd_in   = {cf_r, PAD_W'(0)};
        dv_div_in   = DVS_W'(cols_eff);
        dv_steps_in = STEP_W'(FNB);
        state_nxt   = scfs_pkg::ST_DIVR;
      end
      scfs_pkg::ST_DIVR: begin
        if (!dv_busy_r) begin
          col_nxt   = dv_rem_r[scfs_pkg::COLS_W-1:0];
          row_nxt   = dv_quo_r[FNB-1:0];
          state_nxt = scfs_pkg::ST_MUL;
        end
      end
      scfs_pkg::ST_MUL: begin
        rx_nxt    = prod_x;
        ry_nxt    = XPR_W'(prod_y);
        state_nxt = scfs_pkg::ST_OUT;
      end
      scfs_pkg::ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.rect_x      = rx_r;
          out_data_nxt.rect_y      = ry_r;
          out_data_nxt.shown_frame = cf_w[scfs_pkg::FRAME_W-1:0];
          out_data_nxt.mirrored    = mir_tab_r[sel_r];
          out_data_nxt.is_paused   = paused_r;
          state_nxt                = scfs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = scfs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= scfs_pkg::ST_IDLE;
      acc_r       <= '0;
      pos_r       <= '0;
      paused_r    <= 1'b0;
      sel_r       <= '0;
      cf_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      acc_r       <= acc_nxt;
      pos_r       <= pos_nxt;
      paused_r    <= paused_nxt;
      sel_r       <= sel_nxt;
      cf_r        <= cf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_r       <= in_nxt;
    out_data_r <= out_data_nxt;
    n_r        <= n_nxt;
    p_r        <= p_nxt;
    col_r      <= col_nxt;
    row_r      <= row_nxt;
    rx_r       <= rx_nxt;
    ry_r       <= ry_nxt;
  end

  assign in_ready  = (state_r == scfs_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: design/scfs_checker.sv
// ---------------------------------------------------------------------------
// scfs_checker
// Port-level checks of the sprite clip frame sequencer, bound to the top.
// ---------------------------------------------------------------------------
`include "sprite_clip_frame_sequencer_assert.svh"

module scfs_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input scfs_pkg::out_word_t out_data
);

  // words taken in but not yet delivered
  logic [1:0] pend_r, pend_nxt;

  assign pend_nxt = pend_r + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  `SCFS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  `SCFS_ASSERT_NOW(a_out_drop, $fell(out_valid), $past(out_ready))
  `SCFS_ASSERT_NOW(a_no_extra_word, out_valid, pend_r != 2'd0)
  `SCFS_ASSERT_NOW(a_two_in_flight, pend_r == 2'd2, !in_ready)

endmodule

bind sprite_clip_frame_sequencer scfs_checker u_scfs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
